>>> src/fcac_pkg.sv
// Shared types and constants for the four-channel average and calibrate block.
package fcac_pkg;

  // One input beat: one reading from each converter channel.
  typedef struct packed {
    logic [15:0] sample_ch0;
    logic [15:0] sample_ch1;
    logic [15:0] sample_ch2;
    logic [15:0] sample_ch3;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic        [31:0] filament_current;
    logic        [30:0] mesh_voltage;
    logic signed [31:0] energy_voltage;
    logic        [30:0] emission_current;
    logic               below_stable;
  } out_beat_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FILAMENT_GAIN    = 3'd0,
    REG_MESH_SLOPE       = 3'd1,
    REG_MESH_OFFSET      = 3'd2,
    REG_EMISSION_GAIN    = 3'd3,
    REG_ENERGY_SLOPE     = 3'd4,
    REG_ENERGY_OFFSET    = 3'd5,
    REG_LEAK_FACTOR      = 3'd6,
    REG_STABLE_THRESHOLD = 3'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic [31:0] RST_FILAMENT_GAIN    = 32'd413403;
  localparam logic [31:0] RST_MESH_SLOPE       = 32'd26538603;
  localparam logic [31:0] RST_MESH_OFFSET      = 32'd10205;
  localparam logic [31:0] RST_EMISSION_GAIN    = 32'd2899191;
  localparam logic [31:0] RST_ENERGY_SLOPE     = 32'd32212255;
  localparam logic [31:0] RST_ENERGY_OFFSET    = 32'd8749;
  localparam logic [31:0] RST_LEAK_FACTOR      = 32'd260301048;
  localparam logic [30:0] RST_STABLE_THRESHOLD = 31'd1638400;

  // Readings on channel 1 with this bit set count as zero.
  localparam int unsigned CH1_INVALID_BIT = 15;

  // Serial multiplier geometry.
  localparam int unsigned MCAND_W   = 34;
  localparam int unsigned MPLR_W    = 32;
  localparam int unsigned MCNT_W    = 5;
  localparam logic [MCNT_W-1:0] MCNT_SHORT = 5'd15;
  localparam logic [MCNT_W-1:0] MCNT_LONG  = 5'd31;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_ACC = 2'd0,
    ST_DIV = 2'd1,
    ST_MUL = 2'd2,
    ST_OUT = 2'd3
  } fcac_state_t;

  // Product being formed by the shared multiplier.
  typedef enum logic [2:0] {
    STEP_FIL  = 3'd0,
    STEP_MESH = 3'd1,
    STEP_EMI  = 3'd2,
    STEP_EN   = 3'd3,
    STEP_LEAK = 3'd4
  } fcac_step_t;

  // Control from the sequencer to the multiplier.
  typedef struct packed {
    logic start;
    logic long_run;
  } mul_ctl_t;

endpackage

>>> src/fcac_div.sv
// Four-lane restoring divider by the constant sample count, one quotient bit per cycle.
module fcac_div import fcac_pkg::*; #(
  parameter int unsigned SAMPLES = 20,
  parameter int unsigned SUM_W   = 21
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [3:0][SUM_W-1:0]     dividend,
  output logic                      done,
  output logic [3:0][15:0]          quotient
);

  localparam int unsigned DV_W  = $clog2(SAMPLES + 1);
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);
  localparam logic [DV_W:0] DIVISOR = (DV_W + 1)'(SAMPLES);

  logic [3:0][SUM_W-1:0] dvd_r, dvd_nxt;
  logic [3:0][DV_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [3:0][DV_W:0]    trial;

  // Each lane shifts one dividend bit into its remainder and keeps the quotient bit.
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      trial[i] = {rem_r[i], dvd_r[i][SUM_W-1]};
    end
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 4; i++) begin
        if (trial[i] >= DIVISOR) begin
          rem_nxt[i] = DV_W'(trial[i] - DIVISOR);
          dvd_nxt[i] = {dvd_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i][DV_W-1:0];
          dvd_nxt[i] = {dvd_r[i][SUM_W-2:0], 1'b0};
        end
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quotient[i] = dvd_r[i][15:0];
    end
  end

endmodule

>>> src/fcac_mul.sv
// Shift-and-add multiplier: signed multiplicand times unsigned multiplier, one bit per cycle.
module fcac_mul import fcac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mul_ctl_t                  ctl,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MPLR_W-1:0]         mplr,
  output logic                      done,
  output logic signed [MCAND_W-1:0] prod_hi
);

  logic signed [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic signed [MCAND_W-1:0] hi_r, hi_nxt;
  logic [MPLR_W-1:0]         lo_r, lo_nxt;
  logic [MCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic signed [MCAND_W:0]   partial;

  // Add the multiplicand when the low multiplier bit is set, then shift the pair right.
  always_comb begin
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (lo_r[0]) begin
      partial = {hi_r[MCAND_W-1], hi_r} + {mcand_r[MCAND_W-1], mcand_r};
    end else begin
      partial = {hi_r[MCAND_W-1], hi_r};
    end
    if (ctl.start) begin
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplr;
      cnt_nxt   = ctl.long_run ? MCNT_LONG : MCNT_SHORT;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      hi_nxt = partial[MCAND_W:1];
      lo_nxt = {partial[0], lo_r[MPLR_W-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign done    = done_r;
  assign prod_hi = hi_r;

endmodule

>>> src/four_channel_average_calibrate_top.sv
// Top level of the four-channel average and calibrate block.
// Each accepted beat adds its four readings into the channel sums. The beat that
// completes SAMPLES readings starts a calculation during which no input is taken:
// a bit-serial divider forms the four averages, then the shared bit-serial
// multiplier forms four 16-step products and one 32-step product, and then the
// result register is loaded. The result waits in its output register while new
// beats are accumulated; a new result is held back until the previous one is taken.
module four_channel_average_calibrate_top import fcac_pkg::*; #(
  parameter int unsigned SAMPLES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned SUM_W = 16 + $clog2(SAMPLES);
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam logic [CNT_W:0] LAST_COUNT = (CNT_W + 1)'(SAMPLES);

  // Configuration registers.
  logic [31:0] filament_gain_r, mesh_slope_r, mesh_offset_r, emission_gain_r;
  logic [31:0] energy_slope_r, energy_offset_r, leak_factor_r;
  logic [30:0] stable_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filament_gain_r    <= RST_FILAMENT_GAIN;
      mesh_slope_r       <= RST_MESH_SLOPE;
      mesh_offset_r      <= RST_MESH_OFFSET;
      emission_gain_r    <= RST_EMISSION_GAIN;
      energy_slope_r     <= RST_ENERGY_SLOPE;
      energy_offset_r    <= RST_ENERGY_OFFSET;
      leak_factor_r      <= RST_LEAK_FACTOR;
      stable_threshold_r <= RST_STABLE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILAMENT_GAIN:    filament_gain_r    <= cfg_data;
        REG_MESH_SLOPE:       mesh_slope_r       <= cfg_data;
        REG_MESH_OFFSET:      mesh_offset_r      <= cfg_data;
        REG_EMISSION_GAIN:    emission_gain_r    <= cfg_data;
        REG_ENERGY_SLOPE:     energy_slope_r     <= cfg_data;
        REG_ENERGY_OFFSET:    energy_offset_r    <= cfg_data;
        REG_LEAK_FACTOR:      leak_factor_r      <= cfg_data;
        REG_STABLE_THRESHOLD: stable_threshold_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  fcac_state_t           state_r, state_nxt;
  fcac_step_t            step_r, step_nxt;
  logic                  go_r, go_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [3:0][SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [15:0]           ch1_value;
  logic [31:0]           fil_r, fil_nxt;
  logic [30:0]           mesh_r, mesh_nxt;
  logic [31:0]           p2_r, p2_nxt;
  logic [31:0]           energy_r, energy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  logic                  div_start, div_done;
  logic [3:0][15:0]      avg;
  mul_ctl_t              mul_ctl;
  logic signed [MCAND_W-1:0] mcand, mul_prod;
  logic [MPLR_W-1:0]     mplr;
  logic                  mul_done;
  logic [34:0]           off_sum, emi_diff;
  logic [31:0]           offset_sel;
  logic                  in_fire;

  // Divider for the four averages.
  fcac_div #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .done     (div_done),
    .quotient (avg)
  );

  // Shared multiplier for all calibration products.
  fcac_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .mcand   (mcand),
    .mplr    (mplr),
    .done    (mul_done),
    .prod_hi (mul_prod)
  );

  // Channel 1 readings flagged invalid add nothing.
  assign ch1_value = in_data.sample_ch1[CH1_INVALID_BIT] ? 16'd0 : in_data.sample_ch1;

  always_comb begin
    sum_add[0] = sum_r[0] + SUM_W'(in_data.sample_ch0);
    sum_add[1] = sum_r[1] + SUM_W'(ch1_value);
    sum_add[2] = sum_r[2] + SUM_W'(in_data.sample_ch2);
    sum_add[3] = sum_r[3] + SUM_W'(in_data.sample_ch3);
  end

  // Operand selection for the product in progress.
  always_comb begin
    case (step_r)
      STEP_FIL: begin
        mcand = {2'b00, filament_gain_r};
        mplr  = {16'd0, avg[0]};
      end
      STEP_MESH: begin
        mcand = {2'b00, mesh_slope_r};
        mplr  = {16'd0, avg[1]};
      end
      STEP_EMI: begin
        mcand = {2'b00, emission_gain_r};
        mplr  = {16'd0, avg[2]};
      end
      STEP_EN: begin
        mcand = {2'b00, energy_slope_r};
        mplr  = {16'd0, avg[3]};
      end
      STEP_LEAK: begin
        mcand = {{2{energy_r[31]}}, energy_r};
        mplr  = leak_factor_r;
      end
      default: begin
        mcand = '0;
        mplr  = '0;
      end
    endcase
  end

  assign mul_ctl.start    = go_r;
  assign mul_ctl.long_run = (step_r == STEP_LEAK);

  // Offset add for mesh and energy, and the bleed subtraction for emission.
  assign offset_sel = (step_r == STEP_MESH) ? mesh_offset_r : energy_offset_r;
  assign off_sum    = {mul_prod[MCAND_W-1], mul_prod} + {{3{offset_sel[31]}}, offset_sel};
  assign emi_diff   = {3'b000, p2_r} - {mul_prod[MCAND_W-1], mul_prod};

  assign in_ready = (state_r == ST_ACC);
  assign in_fire  = in_valid && in_ready;

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    go_nxt        = 1'b0;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    fil_nxt       = fil_r;
    mesh_nxt      = mesh_r;
    p2_nxt        = p2_r;
    energy_nxt    = energy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    case (state_r)
      ST_ACC: begin
        if (in_fire) begin
          if ({1'b0, count_r} + 1'b1 < LAST_COUNT) begin
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_add;
          end else begin
            count_nxt = '0;
            sum_nxt   = '0;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          step_nxt  = STEP_FIL;
          go_nxt    = 1'b1;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          go_nxt = 1'b1;
          case (step_r)
            STEP_FIL: begin
              fil_nxt  = mul_prod[31:0];
              step_nxt = STEP_MESH;
            end
            STEP_MESH: begin
              if (off_sum[34]) begin
                mesh_nxt = '0;
              end else if (|off_sum[33:31]) begin
                mesh_nxt = '1;
              end else begin
                mesh_nxt = off_sum[30:0];
              end
              step_nxt = STEP_EMI;
            end
            STEP_EMI: begin
              p2_nxt   = mul_prod[31:0];
              step_nxt = STEP_EN;
            end
            STEP_EN: begin
              if (off_sum[34] && !(&off_sum[33:31])) begin
                energy_nxt = 32'h8000_0000;
              end else if (!off_sum[34] && (|off_sum[33:31])) begin
                energy_nxt = 32'h7FFF_FFFF;
              end else begin
                energy_nxt = off_sum[31:0];
              end
              step_nxt = STEP_LEAK;
            end
            STEP_LEAK: begin
              go_nxt    = 1'b0;
              state_nxt = ST_OUT;
            end
            default: begin
              go_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_OUT: begin
        // The result beat is loaded only once the output register is free; the bleed
        // product stays in the idle multiplier until then.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.filament_current = fil_r;
          out_data_nxt.mesh_voltage     = mesh_r;
          out_data_nxt.energy_voltage   = energy_r;
          out_data_nxt.below_stable     =
            $signed(energy_r) < $signed({1'b0, stable_threshold_r});
          if (emi_diff[34]) begin
            out_data_nxt.emission_current = '0;
          end else if (|emi_diff[33:31]) begin
            out_data_nxt.emission_current = '1;
          end else begin
            out_data_nxt.emission_current = emi_diff[30:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACC;
        end
      end

      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_r      <= STEP_FIL;
      go_r        <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      go_r        <= go_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fil_r      <= fil_nxt;
    mesh_r     <= mesh_nxt;
    p2_r       <= p2_nxt;
    energy_r   <= energy_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/four_channel_average_calibrate_top_tb.sv
// Testbench for the four-channel average and calibrate block, checked against a scoreboard.
module four_channel_average_calibrate_top_tb;
  import fcac_pkg::*;

  localparam int SAMPLES        = 20;
  localparam int SETS_PER_PHASE = 3;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 600;
  localparam int QUIET_LIMIT    = 3000;

  // Shapes a channel can take across one averaging set.
  typedef enum int {
    LVL_NOISE,
    LVL_ZERO,
    LVL_FULL,
    LVL_NEAR,
    LVL_LOW_HALF
  } level_kind_t;

  // Calibration settings applied phase by phase.
  typedef enum int {
    SET_RESET_DEFAULTS,
    SET_ALL_MAX,
    SET_ALL_ZERO,
    SET_NEG_OFFSETS,
    SET_RANDOM
  } cal_setting_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_FILAMENT_GAIN;
  logic [31:0] cfg_data  = '0;

  // Beats waiting to be driven and readouts waiting to arrive.
  in_beat_t  pending_beats [$];
  out_beat_t expected_readouts [$];

  // Local copy of the calibration registers and the accumulation state.
  logic [31:0] cal_reg [8];
  logic [20:0] acc_sum [4];
  logic [4:0]  acc_count;

  bit in_taken   = 1'b0;
  bit out_taken  = 1'b0;
  bit no_idle    = 1'b0;
  bit hold_arm   = 1'b0;
  bit hold_done  = 1'b0;
  int in_wait    = 0;
  int out_wait   = 0;
  int out_gap    = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int error_count = 0;
  out_beat_t want;

  four_channel_average_calibrate_top #(
    .SAMPLES (SAMPLES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Q0.32 gain times an average count, giving Q16.16.
  function automatic longint q16_scale(logic [15:0] avg, logic [31:0] gain);
    logic [63:0] prod;
    prod = {48'b0, avg} * {32'b0, gain};
    return longint'(prod >> 16);
  endfunction

  // Turns the four channel sums into one calibrated readout.
  function automatic out_beat_t calibrate_sums();
    logic [15:0] avg [4];
    longint mesh, energy, emission, bleed;
    out_beat_t r;
    for (int c = 0; c < 4; c++) avg[c] = 16'(acc_sum[c] / SAMPLES);

    mesh = q16_scale(avg[1], cal_reg[REG_MESH_SLOPE])
         + longint'($signed(cal_reg[REG_MESH_OFFSET]));
    if (mesh < 0) mesh = 0;
    if (mesh > 64'sh7FFF_FFFF) mesh = 64'sh7FFF_FFFF;

    energy = q16_scale(avg[3], cal_reg[REG_ENERGY_SLOPE])
           + longint'($signed(cal_reg[REG_ENERGY_OFFSET]));
    if (energy > 64'sh7FFF_FFFF) energy = 64'sh7FFF_FFFF;
    if (energy < -64'sh8000_0000) energy = -64'sh8000_0000;

    // The arithmetic shift floors negative bleed terms toward minus infinity.
    bleed = (energy * longint'({32'b0, cal_reg[REG_LEAK_FACTOR]})) >>> 32;
    emission = q16_scale(avg[2], cal_reg[REG_EMISSION_GAIN]) - bleed;
    if (emission < 0) emission = 0;
    if (emission > 64'sh7FFF_FFFF) emission = 64'sh7FFF_FFFF;

    r.filament_current = 32'(q16_scale(avg[0], cal_reg[REG_FILAMENT_GAIN]));
    r.mesh_voltage     = mesh[30:0];
    r.energy_voltage   = energy[31:0];
    r.emission_current = emission[30:0];
    r.below_stable     = energy < longint'({33'b0, cal_reg[REG_STABLE_THRESHOLD][30:0]});
    return r;
  endfunction

  // Adds one accepted beat; the last beat of a set yields a readout and clears the sums.
  task automatic take_reading(in_beat_t b);
    logic [15:0] mesh_raw;
    mesh_raw = b.sample_ch1[CH1_INVALID_BIT] ? 16'd0 : b.sample_ch1;
    acc_sum[0] = acc_sum[0] + b.sample_ch0;
    acc_sum[1] = acc_sum[1] + mesh_raw;
    acc_sum[2] = acc_sum[2] + b.sample_ch2;
    acc_sum[3] = acc_sum[3] + b.sample_ch3;
    if (acc_count + 1 < SAMPLES) begin
      acc_count = acc_count + 1'b1;
    end else begin
      expected_readouts.push_back(calibrate_sums());
      acc_count = '0;
      for (int c = 0; c < 4; c++) acc_sum[c] = '0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [15:0] pick_reading(level_kind_t kind, logic [15:0] base);
    case (kind)
      LVL_ZERO:     return 16'h0000;
      LVL_FULL:     return 16'hFFFF;
      LVL_NEAR:     return base ^ 16'($urandom_range(0, 255));
      LVL_LOW_HALF: return base & 16'h7FFF;
      default:      return 16'($urandom);
    endcase
  endfunction

  // One full averaging set, each channel following its own shape.
  task automatic queue_random_set();
    level_kind_t kind [4];
    logic [15:0] base [4];
    in_beat_t b;
    for (int c = 0; c < 4; c++) begin
      kind[c] = level_kind_t'($urandom_range(0, 4));
      base[c] = 16'($urandom);
    end
    repeat (SAMPLES) begin
      b.sample_ch0 = pick_reading(kind[0], base[0]);
      b.sample_ch1 = pick_reading(kind[1], base[1]);
      b.sample_ch2 = pick_reading(kind[2], base[2]);
      b.sample_ch3 = pick_reading(kind[3], base[3]);
      pending_beats.push_back(b);
    end
  endtask

  function automatic logic [31:0] setting_value(cal_setting_t s, cfg_reg_t r);
    logic is_offset;
    is_offset = (r == REG_MESH_OFFSET) || (r == REG_ENERGY_OFFSET);
    case (s)
      SET_ALL_MAX:  return is_offset ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      SET_ALL_ZERO: return 32'h0;
      SET_NEG_OFFSETS: begin
        if (is_offset) return 32'h8000_0000;
        return (r == REG_STABLE_THRESHOLD) ? 32'h0 : 32'hFFFF_FFFF;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0;
          1:       return 32'hFFFF_FFFF;
          2:       return $urandom_range(0, 32'h0100_0000);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Register writes happen only while the block is idle.
  task automatic write_register(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    cal_reg[idx] = (idx == REG_STABLE_THRESHOLD) ? {1'b0, val[30:0]} : val;
  endtask

  // Waits until every beat is taken and every readout has arrived, then lets the block settle.
  task automatic drain_and_settle();
    @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_readouts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: holds each beat until taken, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        in_valid <= 1'b1;
      end else if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (pending_beats.size() > 0) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        in_wait  <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input monitor: every accepted beat goes to the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) take_reading(in_data);
    end
  end

  // Result receiver: one long hold-off, otherwise a drawn stall after each beat.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (out_taken) begin
        out_gap = draw_gap();
        out_ready <= (out_gap == 0);
        out_wait  <= (out_gap == 0) ? 0 : out_gap - 1;
      end else if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait  <= out_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor: compares each beat with the oldest pending readout.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (expected_readouts.size() == 0) begin
          report_mismatch("unexpected result beat", out_data.filament_current, 32'h0);
        end else begin
          want = expected_readouts.pop_front();
          compare_field("filament_current", out_data.filament_current, want.filament_current);
          compare_field("mesh_voltage", 32'(out_data.mesh_voltage),
                        32'(want.mesh_voltage));
          compare_field("energy_voltage", out_data.energy_voltage, want.energy_voltage);
          compare_field("emission_current", 32'(out_data.emission_current),
                        32'(want.emission_current));
          compare_field("below_stable", 32'(out_data.below_stable),
                        32'(want.below_stable));
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no beat or write.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: a directed set at reset values, then phases with new calibration each.
  initial begin
    in_beat_t b;
    cal_setting_t setting;
    cal_reg[REG_FILAMENT_GAIN]    = RST_FILAMENT_GAIN;
    cal_reg[REG_MESH_SLOPE]       = RST_MESH_SLOPE;
    cal_reg[REG_MESH_OFFSET]      = RST_MESH_OFFSET;
    cal_reg[REG_EMISSION_GAIN]    = RST_EMISSION_GAIN;
    cal_reg[REG_ENERGY_SLOPE]     = RST_ENERGY_SLOPE;
    cal_reg[REG_ENERGY_OFFSET]    = RST_ENERGY_OFFSET;
    cal_reg[REG_LEAK_FACTOR]      = RST_LEAK_FACTOR;
    cal_reg[REG_STABLE_THRESHOLD] = {1'b0, RST_STABLE_THRESHOLD};
    acc_count = '0;
    for (int c = 0; c < 4; c++) acc_sum[c] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale channels; channel 1 walks through valid maximum, flagged and zero readings.
    for (int k = 0; k < SAMPLES; k++) begin
      b.sample_ch0 = 16'hFFFF;
      b.sample_ch2 = 16'hFFFF;
      b.sample_ch3 = 16'hFFFF;
      case (k % 4)
        0:       b.sample_ch1 = 16'h7FFF;
        1:       b.sample_ch1 = 16'h8000;
        2:       b.sample_ch1 = 16'hFFFF;
        default: b.sample_ch1 = 16'h0000;
      endcase
      pending_beats.push_back(b);
    end
    // A partial set of zeros carries over into the next phase.
    repeat (3) pending_beats.push_back('0);
    drain_and_settle();

    for (int phase = 1; phase <= 7; phase++) begin
      setting = (phase < SET_RANDOM) ? cal_setting_t'(phase) : SET_RANDOM;
      no_idle = (phase % 3 == 0);
      if (phase == 1) hold_arm = 1'b1;
      for (int r = 0; r < 8; r++)
        write_register(cfg_reg_t'(r), setting_value(setting, cfg_reg_t'(r)));
      @(posedge clk);
      repeat (SETS_PER_PHASE) queue_random_set();
      repeat ($urandom_range(0, SAMPLES - 1)) begin
        b = in_beat_t'({$urandom, $urandom});
        pending_beats.push_back(b);
      end
      drain_and_settle();
    end

    if (error_count == 0 && expected_readouts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
